FILE: design/sip_pkg.sv
`timescale 1ns / 1ps

package sip_pkg;

	// default widths of the internal value and offset arithmetic
	localparam int DEF_VALUE_BITS  = 32;
	localparam int DEF_OFFSET_BITS = 16;

	// fixed port widths
	localparam int CHAR_BITS     = 8;
	localparam int RES_VAL_BITS  = 32;
	localparam int RES_OFF_BITS  = 16;
	localparam int BASE_BITS     = 6;
	localparam int CFG_DATA_BITS = 6;
	localparam int CFG_IDX_BITS  = 1;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_NUMBER_BASE = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_SIGNED_MODE = 1'd1;

	// register reset values
	localparam logic [BASE_BITS-1:0] RST_NUMBER_BASE = 6'd10;
	localparam logic                 RST_SIGNED_MODE = 1'b1;

	// bases
	localparam logic [BASE_BITS-1:0] BASE_AUTO = 6'd0;
	localparam logic [BASE_BITS-1:0] BASE_MIN  = 6'd2;
	localparam logic [BASE_BITS-1:0] BASE_OCT  = 6'd8;
	localparam logic [BASE_BITS-1:0] BASE_DEC  = 6'd10;
	localparam logic [BASE_BITS-1:0] BASE_HEX  = 6'd16;
	localparam logic [BASE_BITS-1:0] BASE_MAX  = 6'd36;

	// characters
	localparam logic [CHAR_BITS-1:0] CH_TAB     = 8'd9;
	localparam logic [CHAR_BITS-1:0] CH_CR      = 8'd13;
	localparam logic [CHAR_BITS-1:0] CH_SPACE   = 8'h20;
	localparam logic [CHAR_BITS-1:0] CH_PLUS    = 8'd43;
	localparam logic [CHAR_BITS-1:0] CH_MINUS   = 8'd45;
	localparam logic [CHAR_BITS-1:0] CH_ZERO    = 8'd48;
	localparam logic [CHAR_BITS-1:0] CH_LOWER_A = 8'd97;
	localparam logic [CHAR_BITS-1:0] CH_LOWER_X = 8'd120;
	localparam logic [CHAR_BITS-1:0] CASE_BIT   = 8'h20;
	localparam logic [CHAR_BITS-1:0] LETTER_OFS = 8'd87;
	localparam logic [CHAR_BITS-1:0] NOT_DIGIT  = 8'd40;
	localparam logic [CHAR_BITS-1:0] DEC_TOP    = 8'd9;

	typedef struct packed {
		logic [RES_VAL_BITS-1:0] value;
		logic [RES_OFF_BITS-1:0] end_offset;
		logic                    overflowed;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic emit;      // push a result item
		logic set_neg;   // take the sign character
		logic adv;       // step the character position
		logic zero_pfx;  // leading zero under auto or hex base
		logic set_hex;   // x after the leading zero
		logic digit;     // accumulate one digit
	} sip_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_space;
		logic is_sign;
		logic is_zero;
		logic is_x;
		logic digit_ok;
		logic base_illegal;
		logic base_pfx;
	} sip_status_t;

	// character value as a digit, 36 or more where it is none
	function automatic logic [CHAR_BITS-1:0] digit_of(input logic [CHAR_BITS-1:0] c);
		logic [CHAR_BITS-1:0] t;
		logic [CHAR_BITS-1:0] l;
		t = c - CH_ZERO;
		l = c | CASE_BIT;
		if (t <= DEC_TOP)
			return t;
		return (l >= CH_LOWER_A) ? l - LETTER_OFS : NOT_DIGIT;
	endfunction

endpackage

FILE: design/sip_ifs.sv
`timescale 1ns / 1ps

interface sip_in_if import sip_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CHAR_BITS-1:0] character;
	logic                 string_start;

	modport source (output valid, character, string_start, input ready);
	modport sink   (input valid, character, string_start, output ready);
endinterface

interface sip_out_if import sip_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [RES_VAL_BITS-1:0] value;
	logic [RES_OFF_BITS-1:0] end_offset;
	logic                    overflowed;

	modport source (output valid, value, end_offset, overflowed, input ready);
	modport sink   (input valid, value, end_offset, overflowed, output ready);
endinterface

FILE: design/sip_ctrl.sv
`timescale 1ns / 1ps

module sip_ctrl import sip_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_fire,
	input  logic        start,
	input  sip_status_t st,
	output logic        clear,
	output sip_cmd_t    cmd
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SPACE,
		PH_PREFIX,
		PH_XMARK,
		PH_DIGITS
	} phase_t;

	phase_t phase_q;
	phase_t phase_d;
	phase_t eff;
	logic   to_pfx;
	logic   to_digit;

	// start of string: reload base, clear accumulation
	assign clear = in_fire && start;

	always_comb begin
		cmd      = '0;
		phase_d  = phase_q;
		eff      = phase_q;
		to_pfx   = 1'b0;
		to_digit = 1'b0;
		if (in_fire) begin
			if (start && st.base_illegal) begin
				cmd.emit = 1'b1;
				phase_d  = PH_IDLE;
			end else begin
				eff     = start ? PH_SPACE : phase_q;
				phase_d = eff;
				unique case (eff)
					PH_IDLE: begin
					end
					PH_SPACE: begin
						if (st.is_space) begin
							cmd.adv = 1'b1;
						end else if (st.is_sign) begin
							cmd.set_neg = 1'b1;
							cmd.adv     = 1'b1;
							phase_d     = PH_PREFIX;
						end else begin
							to_pfx = 1'b1;
						end
					end
					PH_PREFIX: to_pfx = 1'b1;
					PH_XMARK: begin
						if (st.is_x) begin
							cmd.set_hex = 1'b1;
							cmd.adv     = 1'b1;
							phase_d     = PH_DIGITS;
						end else begin
							to_digit = 1'b1;
						end
					end
					PH_DIGITS: to_digit = 1'b1;
					default: begin
					end
				endcase
				if (to_pfx) begin
					if (st.base_pfx && st.is_zero) begin
						cmd.zero_pfx = 1'b1;
						cmd.adv      = 1'b1;
						phase_d      = PH_XMARK;
					end else begin
						to_digit = 1'b1;
					end
				end
				if (to_digit) begin
					if (st.digit_ok) begin
						cmd.digit = 1'b1;
						cmd.adv   = 1'b1;
						phase_d   = PH_DIGITS;
					end else begin
						cmd.emit = 1'b1;
						phase_d  = PH_IDLE;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	// a result always closes the string
	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> phase_q == PH_IDLE)
		else $error("parse not idle after result");

	// one character does one kind of work
	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.emit, cmd.digit, cmd.zero_pfx, cmd.set_hex, cmd.set_neg}))
		else $error("conflicting commands");

	// idle characters outside a string do nothing
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE && !clear) |-> (!cmd.adv && !cmd.emit))
		else $error("idle character acted on");

endmodule

FILE: design/sip_dp.sv
`timescale 1ns / 1ps

module sip_dp import sip_pkg::*; #(
	parameter int VALUE_BITS  = DEF_VALUE_BITS,
	parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic [CHAR_BITS-1:0]     character,
	input  logic                     clear,
	input  sip_cmd_t                 cmd,
	output sip_status_t              st,
	output result_t                  result
);

	localparam int PROD_BITS = VALUE_BITS + BASE_BITS;

	logic [BASE_BITS-1:0]   number_base_q;
	logic                   signed_mode_q;

	logic [BASE_BITS-1:0]   base_q;
	logic                   neg_q;
	logic [VALUE_BITS-1:0]  acc_q;
	logic                   sat_q;
	logic [OFFSET_BITS-1:0] pos_q;
	logic [OFFSET_BITS-1:0] fail_q;

	// state as seen by this character: cleared, base reloaded, on the first one of a string
	logic [BASE_BITS-1:0]   eff_base;
	logic                   eff_neg;
	logic [VALUE_BITS-1:0]  eff_acc;
	logic                   eff_sat;
	logic [OFFSET_BITS-1:0] eff_pos;
	logic [OFFSET_BITS-1:0] eff_fail;

	logic [OFFSET_BITS-1:0] pos_next;
	logic [BASE_BITS-1:0]   dig_base;
	logic [CHAR_BITS-1:0]   dig;
	logic [PROD_BITS-1:0]   prod;
	logic                   prod_ovf;

	logic                   out_neg;
	logic [VALUE_BITS-1:0]  lim;
	logic                   clamped;
	logic [VALUE_BITS-1:0]  num;

	assign eff_base = clear ? number_base_q : base_q;
	assign eff_neg  = clear ? 1'b0 : neg_q;
	assign eff_acc  = clear ? '0 : acc_q;
	assign eff_sat  = clear ? 1'b0 : sat_q;
	assign eff_pos  = clear ? '0 : pos_q;
	assign eff_fail = clear ? '0 : fail_q;

	assign pos_next = (eff_pos != '1) ? eff_pos + 1'b1 : eff_pos;

	// auto base that reaches a digit without a leading zero is decimal
	assign dig_base = (eff_base == BASE_AUTO) ? BASE_DEC : eff_base;
	assign dig      = digit_of(character);

	// overflow when acc * base + digit no longer fits
	assign prod     = PROD_BITS'(eff_acc) * PROD_BITS'(dig_base)
	                + PROD_BITS'(dig[BASE_BITS-1:0]);
	assign prod_ovf = |prod[PROD_BITS-1:VALUE_BITS];

	always_comb begin
		st.is_space     = (character == CH_SPACE) || (character >= CH_TAB && character <= CH_CR);
		st.is_sign      = (character == CH_PLUS) || (character == CH_MINUS);
		st.is_zero      = (character == CH_ZERO);
		st.is_x         = ((character | CASE_BIT) == CH_LOWER_X);
		st.digit_ok     = (dig < CHAR_BITS'(dig_base));
		st.base_illegal = !((number_base_q == BASE_AUTO) ||
		                    (number_base_q >= BASE_MIN && number_base_q <= BASE_MAX));
		st.base_pfx     = (eff_base == BASE_AUTO) || (eff_base == BASE_HEX);
	end

	// result: drop the sign of a saturated unsigned value, clamp in signed mode
	always_comb begin
		out_neg = eff_neg && !(eff_sat && !signed_mode_q);
		lim     = {1'b0, {(VALUE_BITS-1){1'b1}}} + VALUE_BITS'(out_neg);
		clamped = signed_mode_q && (eff_acc > lim);
		num     = clamped ? lim : eff_acc;
		if (out_neg)
			num = '0 - num;
		result.value      = RES_VAL_BITS'(num);
		result.end_offset = RES_OFF_BITS'(eff_fail);
		result.overflowed = eff_sat || clamped;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_base_q <= RST_NUMBER_BASE;
			signed_mode_q <= RST_SIGNED_MODE;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_NUMBER_BASE: number_base_q <= cfg_data[BASE_BITS-1:0];
				REG_SIGNED_MODE: signed_mode_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			neg_q  <= 1'b0;
			acc_q  <= '0;
			sat_q  <= 1'b0;
			pos_q  <= '0;
			fail_q <= '0;
		end else begin
			pos_q  <= cmd.adv ? pos_next : eff_pos;
			fail_q <= (cmd.zero_pfx || cmd.digit) ? pos_next : eff_fail;
			neg_q  <= cmd.set_neg ? (character == CH_MINUS) : eff_neg;
			priority if (cmd.zero_pfx)
				base_q <= (eff_base == BASE_AUTO) ? BASE_OCT : BASE_HEX;
			else if (cmd.set_hex)
				base_q <= BASE_HEX;
			else if (cmd.digit)
				base_q <= dig_base;
			else
				base_q <= eff_base;
			if (cmd.digit) begin
				acc_q <= prod_ovf ? '1 : prod[VALUE_BITS-1:0];
				sat_q <= eff_sat || prod_ovf;
			end else begin
				acc_q <= eff_acc;
				sat_q <= eff_sat;
			end
		end
	end

endmodule

FILE: design/sip_obuf.sv
`timescale 1ns / 1ps

module sip_obuf import sip_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    space,
	sip_out_if.source out_ch
);

	result_t main_q;
	result_t skid_q;
	logic    main_v_q;
	logic    skid_v_q;
	logic    pop;

	assign pop   = main_v_q && out_ch.ready;
	assign space = !skid_v_q;

	assign out_ch.valid      = main_v_q;
	assign out_ch.value      = main_q.value;
	assign out_ch.end_offset = main_q.end_offset;
	assign out_ch.overflowed = main_q.overflowed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else if (!push) begin
				main_v_q <= 1'b0;
			end
		end else if (push) begin
			if (main_v_q)
				skid_v_q <= 1'b1;
			else
				main_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_v_q)
				main_q <= skid_q;
			else if (push)
				main_q <= push_data;
		end else if (push) begin
			if (main_v_q)
				skid_q <= push_data;
			else
				main_q <= push_data;
		end
	end

	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> main_v_q)
		else $error("skid entry without head entry");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !skid_v_q)
		else $error("result pushed into full buffer");

	a_skid_moves_up: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && skid_v_q) |=> (main_v_q && !skid_v_q))
		else $error("skid entry lost on pop");

endmodule

FILE: design/string_to_integer_parser.sv
`timescale 1ns / 1ps

// channel   dir  payload                                   item
// in_ch     in   character[7:0], string_start              one string character
// out_ch    out  value[31:0], end_offset[15:0], overflowed one parse result
// cfg       in   cfg_wr_en, cfg_index[0], cfg_data[5:0]    register write
//
// a character is taken each cycle in_ch is ready and finished in the cycle it is accepted
// a result is registered and offered the cycle after its terminating character if none waits
// the per-cycle path is one multiply of the accumulator by the 6-bit base plus the digit add
// reset clears the parse to idle, empties the result buffer, base 10 and signed mode on
// results go through a two-entry buffer; in_ch stalls only while both entries are full

module string_to_integer_parser import sip_pkg::*; #(
	parameter int VALUE_BITS  = DEF_VALUE_BITS,
	parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	sip_in_if.sink                   in_ch,
	sip_out_if.source                out_ch,
	input  logic                     cfg_wr_en,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	sip_cmd_t    cmd;
	sip_status_t st;
	result_t     result;
	logic        clear;
	logic        buf_space;
	logic        in_fire;

	// accept whenever the result buffer has room for one more item
	assign in_ch.ready = buf_space;
	assign in_fire     = in_ch.valid && buf_space;

	// phase sequencing: whitespace, sign, prefix, digits
	sip_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (in_fire),
		.start   (in_ch.string_start),
		.st      (st),
		.clear   (clear),
		.cmd     (cmd)
	);

	// registers, character classes, accumulate and result shaping
	sip_dp #(
		.VALUE_BITS  (VALUE_BITS),
		.OFFSET_BITS (OFFSET_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.character (in_ch.character),
		.clear     (clear),
		.cmd       (cmd),
		.st        (st),
		.result    (result)
	);

	// output register plus skid entry
	sip_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd.emit),
		.push_data (result),
		.space     (buf_space),
		.out_ch    (out_ch)
	);

endmodule
